// ===== design/pwsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Pulse width sensor frame decoder package
// Shared types, codes and constants for the frame decoder blocks.
// ----------------------------------------------------------------------------
package pwsd_pkg;

    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_PULSE   = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;

    localparam logic [1:0] KIND_HUM     = 2'd0;
    localparam logic [1:0] KIND_TEMP    = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;
    localparam logic [1:0] KIND_INVALID = 2'd3;

    localparam logic [15:0] HUM_TAG          = 16'h4000;
    localparam logic [15:0] ERR_TIMEOUT_WORD = 16'hC001;
    localparam logic [15:0] ERR_INVALID_WORD = 16'hC002;

    localparam int         FRAME_BITS  = 40;
    localparam logic [5:0] LAST_PULSE  = 6'd41;
    localparam logic [5:0] RESP_PULSE  = 6'd1;
    localparam logic [5:0] FIRST_BIT   = 6'd2;
    localparam logic [3:0] INVALID_MAX = 4'd15;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_W = 5;
    localparam logic [2:0] REG_RESP_MIN      = 3'd0;
    localparam logic [2:0] REG_RESP_MAX      = 3'd1;
    localparam logic [2:0] REG_ZERO_MIN      = 3'd2;
    localparam logic [2:0] REG_ZERO_MAX      = 3'd3;
    localparam logic [2:0] REG_ONE_MIN       = 3'd4;
    localparam logic [2:0] REG_ONE_MAX       = 3'd5;
    localparam logic [2:0] REG_BAD_FRAME_CAP = 3'd6;

    typedef struct packed {
        logic [7:0] resp_min;
        logic [7:0] resp_max;
        logic [7:0] zero_min;
        logic [7:0] zero_max;
        logic [7:0] one_min;
        logic [7:0] one_max;
    } pwsd_win_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       resp_ok;
        logic       is_zero;
        logic       is_one;
    } pwsd_cmd_t;

endpackage

// ===== design/pulse_width_sensor_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// Pulse width sensor frame decoder core
// An input transfer is held in the queue; the frame engine then registers any result.
// Throughput: one transfer per cycle; a held result stalls the input once the queue fills.
// Reset: synchronous, aresetn low; config registers take defaults, frame state clears.
// ----------------------------------------------------------------------------
module pulse_width_sensor_frame_decoder_core #(
    parameter int PULSE_WIDTH_BITS = 8
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // s_tdata: pulse_width, zero padded to whole bytes.
    input  logic [((PULSE_WIDTH_BITS+7)/8)*8-1:0]     s_tdata,
    // s_tuser: mode.
    input  logic [1:0]                                s_tuser,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // m_tdata: word.
    output logic [15:0]                               m_tdata,
    // m_tuser: kind.
    output logic [1:0]                                m_tuser,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [pwsd_pkg::PADDR_W-1:0]              paddr,
    input  logic [31:0]                               pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);

    pwsd_pkg::pwsd_win_t win_reg;
    logic [3:0]          limit_reg;
    logic [2:0]          reg_index;
    logic                cfg_write;
    logic                queue_full;
    logic                queue_not_empty;
    logic                push;
    logic                pop;
    pwsd_pkg::pwsd_cmd_t front_cmd;
    pwsd_pkg::pwsd_cmd_t back_cmd;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg.resp_min <= 8'd72;
            win_reg.resp_max <= 8'd82;
            win_reg.zero_min <= 8'd20;
            win_reg.zero_max <= 8'd30;
            win_reg.one_min  <= 8'd68;
            win_reg.one_max  <= 8'd75;
            limit_reg        <= 4'd5;
        end else if (cfg_write) begin
            unique case (reg_index)
                pwsd_pkg::REG_RESP_MIN:      win_reg.resp_min <= pwdata[7:0];
                pwsd_pkg::REG_RESP_MAX:      win_reg.resp_max <= pwdata[7:0];
                pwsd_pkg::REG_ZERO_MIN:      win_reg.zero_min <= pwdata[7:0];
                pwsd_pkg::REG_ZERO_MAX:      win_reg.zero_max <= pwdata[7:0];
                pwsd_pkg::REG_ONE_MIN:       win_reg.one_min  <= pwdata[7:0];
                pwsd_pkg::REG_ONE_MAX:       win_reg.one_max  <= pwdata[7:0];
                pwsd_pkg::REG_BAD_FRAME_CAP: limit_reg        <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            pwsd_pkg::REG_RESP_MIN:      prdata = {24'd0, win_reg.resp_min};
            pwsd_pkg::REG_RESP_MAX:      prdata = {24'd0, win_reg.resp_max};
            pwsd_pkg::REG_ZERO_MIN:      prdata = {24'd0, win_reg.zero_min};
            pwsd_pkg::REG_ZERO_MAX:      prdata = {24'd0, win_reg.zero_max};
            pwsd_pkg::REG_ONE_MIN:       prdata = {24'd0, win_reg.one_min};
            pwsd_pkg::REG_ONE_MAX:       prdata = {24'd0, win_reg.one_max};
            pwsd_pkg::REG_BAD_FRAME_CAP: prdata = {28'd0, limit_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    pwsd_front #(
        .PULSE_WIDTH_BITS (PULSE_WIDTH_BITS)
    ) u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .pulse_width (s_tdata[PULSE_WIDTH_BITS-1:0]),
        .mode        (s_tuser),
        .win         (win_reg),
        .queue_full  (queue_full),
        .push        (push),
        .cmd         (front_cmd)
    );

    pwsd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .pop_data  (back_cmd)
    );

    pwsd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .bad_frame_cap (limit_reg),
        .cmd_valid     (queue_not_empty),
        .cmd           (back_cmd),
        .pop           (pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_word        (m_tdata),
        .m_kind        (m_tuser)
    );

endmodule

// ===== design/pwsd_front.sv =====
// ----------------------------------------------------------------------------
// Pulse width sensor frame decoder front end
// Accepts input transfers and classifies each pulse width against the windows.
// ----------------------------------------------------------------------------
module pwsd_front #(
    parameter int PULSE_WIDTH_BITS = 8
) (
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [PULSE_WIDTH_BITS-1:0] pulse_width,
    input  logic [1:0]                  mode,
    input  pwsd_pkg::pwsd_win_t         win,
    input  logic                        queue_full,
    output logic                        push,
    output pwsd_pkg::pwsd_cmd_t         cmd
);

    logic [PULSE_WIDTH_BITS-1:0] resp_lo;
    logic [PULSE_WIDTH_BITS-1:0] resp_hi;
    logic [PULSE_WIDTH_BITS-1:0] zero_lo;
    logic [PULSE_WIDTH_BITS-1:0] zero_hi;
    logic [PULSE_WIDTH_BITS-1:0] one_lo;
    logic [PULSE_WIDTH_BITS-1:0] one_hi;
    logic                        in_zero;
    logic                        in_one;

    assign resp_lo = PULSE_WIDTH_BITS'(win.resp_min);
    assign resp_hi = PULSE_WIDTH_BITS'(win.resp_max);
    assign zero_lo = PULSE_WIDTH_BITS'(win.zero_min);
    assign zero_hi = PULSE_WIDTH_BITS'(win.zero_max);
    assign one_lo  = PULSE_WIDTH_BITS'(win.one_min);
    assign one_hi  = PULSE_WIDTH_BITS'(win.one_max);

    assign in_zero = (pulse_width >= zero_lo) && (pulse_width <= zero_hi);
    assign in_one  = (pulse_width >= one_lo) && (pulse_width <= one_hi);

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb begin
        cmd.mode    = mode;
        cmd.resp_ok = (pulse_width >= resp_lo) && (pulse_width <= resp_hi);
        cmd.is_zero = in_zero;
        cmd.is_one  = in_one && !in_zero;
    end

endmodule

// ===== design/pwsd_queue.sv =====
// ----------------------------------------------------------------------------
// Pulse width sensor frame decoder queue
// Short register queue between the front end and the frame engine.
// ----------------------------------------------------------------------------
module pwsd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  pwsd_pkg::pwsd_cmd_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output pwsd_pkg::pwsd_cmd_t pop_data
);

    pwsd_pkg::pwsd_cmd_t                    entry_reg [pwsd_pkg::QUEUE_DEPTH];
    logic [pwsd_pkg::QUEUE_PTR_W-1:0]       wr_ptr_reg;
    logic [pwsd_pkg::QUEUE_PTR_W-1:0]       wr_ptr_next;
    logic [pwsd_pkg::QUEUE_PTR_W-1:0]       rd_ptr_reg;
    logic [pwsd_pkg::QUEUE_PTR_W-1:0]       rd_ptr_next;
    logic [pwsd_pkg::QUEUE_CNT_W-1:0]       count_reg;
    logic [pwsd_pkg::QUEUE_CNT_W-1:0]       count_next;

    assign full      = (count_reg == pwsd_pkg::QUEUE_CNT_W'(pwsd_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == pwsd_pkg::QUEUE_PTR_W'(pwsd_pkg::QUEUE_DEPTH - 1))
                ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == pwsd_pkg::QUEUE_PTR_W'(pwsd_pkg::QUEUE_DEPTH - 1))
                ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/pwsd_back.sv =====
// ----------------------------------------------------------------------------
// Pulse width sensor frame decoder frame engine
// Tracks the frame, assembles the 40 data bits and registers each result.
// ----------------------------------------------------------------------------
module pwsd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [3:0]          bad_frame_cap,
    input  logic                cmd_valid,
    input  pwsd_pkg::pwsd_cmd_t cmd,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_word,
    output logic [1:0]          m_kind
);

    logic                                active_reg;
    logic                                active_next;
    logic [5:0]                          count_reg;
    logic [5:0]                          count_next;
    logic [pwsd_pkg::FRAME_BITS-1:0]     shift_reg;
    logic [pwsd_pkg::FRAME_BITS-1:0]     shift_next;
    logic [pwsd_pkg::FRAME_BITS-1:0]     shift_in;
    logic                                bad_reg;
    logic                                bad_next;
    logic [3:0]                          invalid_reg;
    logic [3:0]                          invalid_next;
    logic                                temp_reg;
    logic                                temp_next;
    logic                                valid_reg;
    logic                                valid_next;
    logic [15:0]                         word_reg;
    logic [15:0]                         word_next;
    logic [1:0]                          kind_reg;
    logic [1:0]                          kind_next;
    logic                                emit;
    logic [15:0]                         hum;
    logic [15:0]                         temp;
    logic [7:0]                          chk;
    logic [7:0]                          sum;

    assign pop      = cmd_valid && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_word   = word_reg;
    assign m_kind   = kind_reg;

    assign shift_in = {shift_reg[pwsd_pkg::FRAME_BITS-2:0], cmd.is_one};
    assign hum      = shift_in[39:24];
    assign temp     = shift_in[23:8];
    assign chk      = shift_in[7:0];
    assign sum      = hum[15:8] + hum[7:0] + temp[15:8] + temp[7:0];

    always_comb begin
        active_next  = active_reg;
        count_next   = count_reg;
        shift_next   = shift_reg;
        bad_next     = bad_reg;
        invalid_next = invalid_reg;
        temp_next    = temp_reg;
        emit         = 1'b0;
        word_next    = word_reg;
        kind_next    = kind_reg;
        if (pop) begin
            unique case (cmd.mode)
                pwsd_pkg::MODE_START: begin
                    active_next = 1'b1;
                    count_next  = '0;
                    shift_next  = '0;
                    bad_next    = 1'b0;
                end
                pwsd_pkg::MODE_TIMEOUT: begin
                    if (active_reg) begin
                        active_next  = 1'b0;
                        count_next   = '0;
                        shift_next   = '0;
                        bad_next     = 1'b0;
                        invalid_next = '0;
                        temp_next    = 1'b0;
                        emit         = 1'b1;
                        word_next    = pwsd_pkg::ERR_TIMEOUT_WORD;
                        kind_next    = pwsd_pkg::KIND_TIMEOUT;
                    end
                end
                pwsd_pkg::MODE_PULSE: begin
                    if (active_reg) begin
                        if (count_reg == pwsd_pkg::RESP_PULSE) begin
                            if (!cmd.resp_ok) begin
                                bad_next = 1'b1;
                            end
                        end else if (count_reg >= pwsd_pkg::FIRST_BIT) begin
                            if (!cmd.is_zero && !cmd.is_one) begin
                                bad_next = 1'b1;
                            end
                            shift_next = shift_in;
                        end
                        if (count_reg >= pwsd_pkg::LAST_PULSE) begin
                            active_next = 1'b0;
                            count_next  = '0;
                            if (bad_next || (sum != chk)) begin
                                if (invalid_reg < pwsd_pkg::INVALID_MAX) begin
                                    invalid_next = invalid_reg + 1'b1;
                                end
                                if (invalid_next >= bad_frame_cap) begin
                                    emit      = 1'b1;
                                    word_next = pwsd_pkg::ERR_INVALID_WORD;
                                    kind_next = pwsd_pkg::KIND_INVALID;
                                end
                            end else begin
                                emit         = 1'b1;
                                invalid_next = '0;
                                temp_next    = !temp_reg;
                                if (temp_reg) begin
                                    word_next = temp;
                                    kind_next = pwsd_pkg::KIND_TEMP;
                                end else begin
                                    word_next = hum + pwsd_pkg::HUM_TAG;
                                    kind_next = pwsd_pkg::KIND_HUM;
                                end
                            end
                        end else begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (emit) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            count_reg   <= '0;
            shift_reg   <= '0;
            bad_reg     <= 1'b0;
            invalid_reg <= '0;
            temp_reg    <= 1'b0;
            valid_reg   <= 1'b0;
        end else begin
            active_reg  <= active_next;
            count_reg   <= count_next;
            shift_reg   <= shift_next;
            bad_reg     <= bad_next;
            invalid_reg <= invalid_next;
            temp_reg    <= temp_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        kind_reg <= kind_next;
    end

endmodule

// ===== bench/pulse_width_sensor_frame_decoder_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pulse width sensor frame decoder core testbench
// Streams start, pulse, timeout and unused mode items into the decoder under several
// window and limit settings, predicts each decoded word in a scoreboard and
// compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module pulse_width_sensor_frame_decoder_core_test;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [15:0] word;
        logic [1:0]  kind;
    } sensor_word_t;

    class frame_scoreboard;
        logic [7:0]   win [6];
        logic [3:0]   bad_frame_cap;
        bit           frame_open;
        logic [5:0]   pulse_idx;
        logic [39:0]  frame_bits;
        bit           frame_bad;
        logic [3:0]   invalid_cnt;
        bit           temp_next;
        sensor_word_t expected_q [$];
        int           errors;

        function new();
            win[pwsd_pkg::REG_RESP_MIN] = 8'd72;
            win[pwsd_pkg::REG_RESP_MAX] = 8'd82;
            win[pwsd_pkg::REG_ZERO_MIN] = 8'd20;
            win[pwsd_pkg::REG_ZERO_MAX] = 8'd30;
            win[pwsd_pkg::REG_ONE_MIN]  = 8'd68;
            win[pwsd_pkg::REG_ONE_MAX]  = 8'd75;
            bad_frame_cap = 4'd5;
            errors = 0;
            clear_frame_state();
        endfunction

        function void clear_frame_state();
            frame_open  = 1'b0;
            pulse_idx   = '0;
            frame_bits  = '0;
            frame_bad   = 1'b0;
            invalid_cnt = '0;
            temp_next   = 1'b0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [7:0] val);
            if (idx == pwsd_pkg::REG_BAD_FRAME_CAP) begin
                bad_frame_cap = val[3:0];
            end else begin
                win[idx] = val;
            end
        endfunction

        function bit in_win(logic [7:0] w, logic [7:0] lo, logic [7:0] hi);
            return w >= lo && w <= hi;
        endfunction

        function void push_word(logic [15:0] word, logic [1:0] kind);
            sensor_word_t item;
            item.word = word;
            item.kind = kind;
            expected_q.push_back(item);
        endfunction

        function void close_frame();
            logic [15:0] hum;
            logic [15:0] tmp;
            logic [7:0]  sum;
            hum = frame_bits[39:24];
            tmp = frame_bits[23:8];
            sum = hum[15:8] + hum[7:0] + tmp[15:8] + tmp[7:0];
            frame_open = 1'b0;
            pulse_idx  = '0;
            if (frame_bad || sum != frame_bits[7:0]) begin
                if (invalid_cnt < pwsd_pkg::INVALID_MAX) invalid_cnt++;
                if (invalid_cnt >= bad_frame_cap)
                    push_word(pwsd_pkg::ERR_INVALID_WORD, pwsd_pkg::KIND_INVALID);
            end else begin
                if (temp_next) push_word(tmp, pwsd_pkg::KIND_TEMP);
                else push_word(hum + pwsd_pkg::HUM_TAG, pwsd_pkg::KIND_HUM);
                temp_next   = !temp_next;
                invalid_cnt = '0;
            end
        endfunction

        function void note_input(logic [1:0] mode, logic [7:0] width);
            logic bit_val;
            case (mode)
                pwsd_pkg::MODE_START: begin
                    frame_open = 1'b1;
                    pulse_idx  = '0;
                    frame_bits = '0;
                    frame_bad  = 1'b0;
                end
                pwsd_pkg::MODE_TIMEOUT: begin
                    if (frame_open) begin
                        clear_frame_state();
                        push_word(pwsd_pkg::ERR_TIMEOUT_WORD, pwsd_pkg::KIND_TIMEOUT);
                    end
                end
                pwsd_pkg::MODE_PULSE: begin
                    if (frame_open) begin
                        if (pulse_idx == pwsd_pkg::RESP_PULSE) begin
                            if (!in_win(width, win[pwsd_pkg::REG_RESP_MIN],
                                        win[pwsd_pkg::REG_RESP_MAX]))
                                frame_bad = 1'b1;
                        end else if (pulse_idx >= pwsd_pkg::FIRST_BIT) begin
                            bit_val = 1'b0;
                            if (in_win(width, win[pwsd_pkg::REG_ZERO_MIN],
                                       win[pwsd_pkg::REG_ZERO_MAX]))
                                bit_val = 1'b0;
                            else if (in_win(width, win[pwsd_pkg::REG_ONE_MIN],
                                            win[pwsd_pkg::REG_ONE_MAX]))
                                bit_val = 1'b1;
                            else
                                frame_bad = 1'b1;
                            frame_bits = {frame_bits[38:0], bit_val};
                        end
                        if (pulse_idx >= pwsd_pkg::LAST_PULSE) close_frame();
                        else pulse_idx++;
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(logic [15:0] word, logic [1:0] kind);
            sensor_word_t due;
            if (expected_q.size() == 0) begin
                $error("unexpected result: word %h kind %0d", word, kind);
                errors++;
                return;
            end
            due = expected_q.pop_front();
            if (word !== due.word) begin
                $error("word: expected %h, actual %h", due.word, word);
                errors++;
            end
            if (kind !== due.kind) begin
                $error("kind: expected %0d, actual %0d", due.kind, kind);
                errors++;
            end
        endfunction
    endclass

    logic                       aclk     = 1'b0;
    logic                       aresetn  = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [7:0]                 s_tdata  = '0;
    logic [1:0]                 s_tuser  = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [15:0]                m_tdata;
    logic [1:0]                 m_tuser;
    logic                       psel     = 1'b0;
    logic                       penable  = 1'b0;
    logic                       pwrite   = 1'b0;
    logic [pwsd_pkg::PADDR_W-1:0] paddr  = '0;
    logic [31:0]                pwdata   = '0;
    logic [31:0]                prdata;
    logic                       pready;

    logic                       steady   = 1'b0;
    logic                       hold_req = 1'b0;
    int                         items_sent = 0;
    frame_scoreboard            book;

    pulse_width_sensor_frame_decoder_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic send_item(input logic [1:0] mode, input logic [7:0] width);
        while (!steady && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= width;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        book.note_input(mode, width);
        items_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        book.set_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic set_windows(input logic [7:0] rmin, input logic [7:0] rmax,
                               input logic [7:0] zmin, input logic [7:0] zmax,
                               input logic [7:0] omin, input logic [7:0] omax,
                               input logic [3:0] limit);
        write_reg(pwsd_pkg::REG_RESP_MIN, rmin);
        write_reg(pwsd_pkg::REG_RESP_MAX, rmax);
        write_reg(pwsd_pkg::REG_ZERO_MIN, zmin);
        write_reg(pwsd_pkg::REG_ZERO_MAX, zmax);
        write_reg(pwsd_pkg::REG_ONE_MIN, omin);
        write_reg(pwsd_pkg::REG_ONE_MAX, omax);
        write_reg(pwsd_pkg::REG_BAD_FRAME_CAP, {4'd0, limit});
    endtask

    task automatic drain();
        while (book.expected_q.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick(logic [7:0] lo, logic [7:0] hi);
        if (lo <= hi) return 8'($urandom_range(hi, lo));
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] bit_width(bit is_one);
        logic [7:0] w;
        for (int tries = 0; tries < 4; tries++) begin
            w = is_one ? pick(book.win[pwsd_pkg::REG_ONE_MIN], book.win[pwsd_pkg::REG_ONE_MAX])
                       : pick(book.win[pwsd_pkg::REG_ZERO_MIN],
                              book.win[pwsd_pkg::REG_ZERO_MAX]);
            if (!is_one || !book.in_win(w, book.win[pwsd_pkg::REG_ZERO_MIN],
                                        book.win[pwsd_pkg::REG_ZERO_MAX]))
                break;
        end
        return w;
    endfunction

    task automatic send_frame();
        logic [7:0]  hum_hi, hum_lo, tmp_hi, tmp_lo, chk, w;
        logic [39:0] payload;
        int          cut;
        hum_hi = 8'($urandom);
        hum_lo = 8'($urandom);
        tmp_hi = 8'($urandom);
        tmp_lo = 8'($urandom);
        chk    = hum_hi + hum_lo + tmp_hi + tmp_lo;
        if ($urandom_range(9) == 0) chk = 8'($urandom);
        payload = {hum_hi, hum_lo, tmp_hi, tmp_lo, chk};
        cut = ($urandom_range(29) == 0) ? int'($urandom_range(41, 1)) : 99;
        send_item(pwsd_pkg::MODE_START, 8'($urandom));
        for (int p = 0; p <= 41; p++) begin
            if (p == cut) begin
                send_item(pwsd_pkg::MODE_TIMEOUT, 8'($urandom));
                return;
            end
            if (p == 0) w = 8'($urandom);
            else if (p == 1) w = pick(book.win[pwsd_pkg::REG_RESP_MIN],
                                      book.win[pwsd_pkg::REG_RESP_MAX]);
            else w = bit_width(payload[41-p]);
            if ($urandom_range(99) == 0) w = 8'($urandom);
            send_item(pwsd_pkg::MODE_PULSE, w);
        end
    endtask

    task automatic send_broken();
        int n;
        int r;
        n = int'($urandom_range(45));
        send_item(pwsd_pkg::MODE_START, 8'($urandom));
        for (int i = 0; i < n; i++) begin
            r = int'($urandom_range(99));
            if (r < 85) send_item(pwsd_pkg::MODE_PULSE, 8'($urandom));
            else if (r < 90) send_item(pwsd_pkg::MODE_START, 8'($urandom));
            else if (r < 95) send_item(pwsd_pkg::MODE_TIMEOUT, 8'($urandom));
            else send_item(MODE_UNUSED, 8'($urandom));
        end
    endtask

    task automatic run_random(input int budget);
        int start_count;
        int r;
        start_count = items_sent;
        while (items_sent - start_count < budget) begin
            r = int'($urandom_range(99));
            if (r < 75) begin
                send_frame();
            end else if (r < 87) begin
                send_broken();
            end else begin
                repeat ($urandom_range(4, 1)) send_item(2'($urandom_range(3)), 8'($urandom));
            end
        end
        s_tvalid <= 1'b0;
        drain();
    endtask

    initial begin
        logic [7:0] zmin, zmax, omin, omax, rmin;
        book = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(pwsd_pkg::MODE_PULSE, 8'd0);
        send_item(pwsd_pkg::MODE_TIMEOUT, 8'd0);
        send_item(MODE_UNUSED, 8'd255);
        send_item(pwsd_pkg::MODE_START, 8'd255);
        send_item(pwsd_pkg::MODE_PULSE, 8'd0);
        send_item(pwsd_pkg::MODE_PULSE, 8'd255);
        send_item(pwsd_pkg::MODE_START, 8'd0);
        send_item(pwsd_pkg::MODE_PULSE, 8'd77);
        send_item(pwsd_pkg::MODE_PULSE, 8'd77);
        send_item(MODE_UNUSED, 8'd0);
        send_item(pwsd_pkg::MODE_PULSE, 8'd25);
        send_item(pwsd_pkg::MODE_PULSE, 8'd70);
        send_item(pwsd_pkg::MODE_PULSE, 8'd255);
        send_item(pwsd_pkg::MODE_TIMEOUT, 8'd170);
        send_item(pwsd_pkg::MODE_TIMEOUT, 8'd85);

        // Each start/timeout pair yields a word; a held-off sink stalls the input.
        hold_req <= 1'b1;
        repeat (30) begin
            send_item(pwsd_pkg::MODE_START, 8'($urandom));
            send_item(pwsd_pkg::MODE_TIMEOUT, 8'($urandom));
        end
        s_tvalid <= 1'b0;
        drain();

        run_random(250);

        set_windows(8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 4'd1);
        run_random(250);

        steady <= 1'b1;
        set_windows(8'd100, 8'd110, 8'd10, 8'd60, 8'd40, 8'd200, 4'd15);
        run_random(250);
        steady <= 1'b0;

        set_windows(8'd90, 8'd80, 8'd5, 8'd40, 8'd41, 8'd250, 4'd15);
        run_random(375);

        zmin = 8'($urandom_range(60));
        zmax = zmin + 8'($urandom_range(60));
        omin = zmax + 8'd1 + 8'($urandom_range(60));
        omax = 8'($urandom_range(255, omin));
        rmin = 8'($urandom);
        set_windows(rmin, 8'($urandom_range(255, rmin)), zmin, zmax, omin, omax,
                    4'($urandom_range(15, 1)));
        run_random(250);

        if (book.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        int  hold_left;
        bit  hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) book.check_result(m_tdata, m_tuser);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = 400;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 34);
            end
        end
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
